### rtl/rorf_pkg.sv
`default_nettype none

package rorf_pkg;

  // fixed field widths
  localparam int unsigned CMD_W     = 2;
  localparam int unsigned COORD_W   = 24;
  localparam int unsigned CHAR_W    = 8;
  localparam int unsigned CELL_W    = 8;
  localparam int unsigned DIM_REG_W = 9;
  localparam int unsigned REG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 9;

  // command codes
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DRAW  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

  // register indexes
  localparam logic [REG_IDX_W-1:0] REG_CANVAS_WIDTH    = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_CANVAS_HEIGHT   = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_BACKGROUND_CHAR = 2'd2;

  // register reset values
  localparam logic [DIM_REG_W-1:0] RST_CANVAS_WIDTH    = 9'd256;
  localparam logic [DIM_REG_W-1:0] RST_CANVAS_HEIGHT   = 9'd256;
  localparam logic [CHAR_W-1:0]    RST_BACKGROUND_CHAR = 8'd32;

  typedef struct packed {
    logic [CMD_W-1:0]          cmd;
    logic                      filled;
    logic signed [COORD_W-1:0] rect_left;
    logic signed [COORD_W-1:0] rect_top;
    logic signed [COORD_W-1:0] rect_span_x;
    logic signed [COORD_W-1:0] rect_span_y;
    logic [CHAR_W-1:0]         paint_char;
    logic [CELL_W-1:0]         cell_col;
    logic [CELL_W-1:0]         cell_row;
  } req_t;

  typedef struct packed {
    logic [CHAR_W-1:0] cell_char;
    logic              out_of_range;
  } rsp_t;

endpackage

`default_nettype wire

### rtl/rectangle_outline_fill_rasterizer.sv
`default_nettype none

// channel    dir  handshake                  payload
// request    in   start_i & !busy_o          req_i (rorf_pkg::req_t)
// result     out  rsp_valid_o, one cycle     rsp_o (rorf_pkg::rsp_t)
// config     in   cfg_valid_i & cfg_ready_o  cfg_index_i, cfg_data_i
//
// clear: writes the background char to every canvas cell in use, row by row
// draw: setup in ST_BOX0 and ST_BOX1, then a walk over the clipped bounding box
// read: result strobe in the cycle after the request
// the single-port canvas memory takes one cell access per cycle, which paces
// the walks; rst_ni clears control and config only, the canvas is
// undefined until cleared; results cannot be stalled

module rectangle_outline_fill_rasterizer #(
  parameter int unsigned MAX_DIM   = 256,
  parameter int unsigned FRAC_BITS = 8
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start_i,
  output logic                                     busy_o,
  input  wire rorf_pkg::req_t                      req_i,
  output logic                                     rsp_valid_o,
  output rorf_pkg::rsp_t                           rsp_o,
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [rorf_pkg::REG_IDX_W-1:0]      cfg_index_i,
  input  wire logic [rorf_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  import rorf_pkg::*;

  // counter, dimension, address and coordinate widths
  localparam int unsigned CW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int unsigned DW0   = $clog2(MAX_DIM + 1);
  localparam int unsigned DW    = (DW0 > DIM_REG_W) ? DW0 : DIM_REG_W;
  localparam int unsigned DEPTH = MAX_DIM * MAX_DIM;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned SW0   = CW + FRAC_BITS + 2;
  localparam int unsigned SW    = (SW0 > COORD_W + 3) ? SW0 : COORD_W + 3;

  // sequencer states
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_BOX0  = 3'd1;
  localparam logic [2:0] ST_BOX1  = 3'd2;
  localparam logic [2:0] ST_CLEAR = 3'd3;
  localparam logic [2:0] ST_DRAW  = 3'd4;
  localparam logic [2:0] ST_READ  = 3'd5;

  logic [2:0] state_q, state_d;

  // config registers
  logic [DIM_REG_W-1:0] width_q, height_q;
  logic [CHAR_W-1:0]    bg_q;

  // walk counters and bounds
  logic [CW-1:0] col_q, col_d, row_q, row_d;
  logic [CW-1:0] col_lo_q, col_lo_d, col_hi_q, col_hi_d;
  logic [CW-1:0] row_lo_q, row_lo_d, row_hi_q, row_hi_d;

  // per-request payload
  logic              filled_q, filled_d;
  logic [CHAR_W-1:0] char_q, char_d;
  logic              oor_q, oor_d;

  logic [DW-1:0] w_eff, h_eff;
  logic          accept, in_range, last_col, last_row, on_edge;

  logic signed [SW-1:0] x_pos, y_pos;

  // bounding box unit outputs
  logic                 box_empty;
  logic [CW-1:0]        box_col_lo, box_col_hi, box_row_lo, box_row_hi;
  logic signed [SW-1:0] x_lo_edge, x_hi_edge, y_lo_edge, y_hi_edge;

  // memory port
  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_addr, walk_addr, read_addr;
  logic [CHAR_W-1:0] mem_wdata, mem_rdata;

  assign accept      = start_i && !busy_o;
  assign busy_o      = (state_q != ST_IDLE);
  assign cfg_ready_o = !busy_o;

  // registers above the canvas size saturate
  assign w_eff = (DW'(width_q) > DW'(MAX_DIM)) ? DW'(MAX_DIM) : DW'(width_q);
  assign h_eff = (DW'(height_q) > DW'(MAX_DIM)) ? DW'(MAX_DIM) : DW'(height_q);

  assign in_range = (DW'(req_i.cell_col) < w_eff) && (DW'(req_i.cell_row) < h_eff);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= RST_CANVAS_WIDTH;
      height_q <= RST_CANVAS_HEIGHT;
      bg_q     <= RST_BACKGROUND_CHAR;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_CANVAS_WIDTH:    width_q  <= cfg_data_i;
        REG_CANVAS_HEIGHT:   height_q <= cfg_data_i;
        REG_BACKGROUND_CHAR: bg_q     <= cfg_data_i[CHAR_W-1:0];
        default: ;
      endcase
    end
  end

  rorf_bbox #(
    .FRAC_BITS (FRAC_BITS),
    .CW        (CW),
    .DW        (DW),
    .SW        (SW)
  ) u_bbox (
    .clk_i         (clk_i),
    .load_i        (accept && (req_i.cmd == CMD_DRAW)),
    .rect_left_i   (req_i.rect_left),
    .rect_top_i    (req_i.rect_top),
    .rect_span_x_i (req_i.rect_span_x),
    .rect_span_y_i (req_i.rect_span_y),
    .w_eff_i       (w_eff),
    .h_eff_i       (h_eff),
    .empty_o       (box_empty),
    .col_lo_o      (box_col_lo),
    .col_hi_o      (box_col_hi),
    .row_lo_o      (box_row_lo),
    .row_hi_o      (box_row_hi),
    .x_lo_edge_o   (x_lo_edge),
    .x_hi_edge_o   (x_hi_edge),
    .y_lo_edge_o   (y_lo_edge),
    .y_hi_edge_o   (y_hi_edge)
  );

  // cell position in fixed point, tested against the edge bands
  assign x_pos   = $signed(SW'(col_q)) <<< FRAC_BITS;
  assign y_pos   = $signed(SW'(row_q)) <<< FRAC_BITS;
  assign on_edge = (x_pos < x_lo_edge) || (x_pos > x_hi_edge) ||
                   (y_pos < y_lo_edge) || (y_pos > y_hi_edge);

  assign last_col = (col_q == col_hi_q);
  assign last_row = (row_q == row_hi_q);

  always_comb begin
    state_d  = state_q;
    col_d    = col_q;
    row_d    = row_q;
    col_lo_d = col_lo_q;
    col_hi_d = col_hi_q;
    row_lo_d = row_lo_q;
    row_hi_d = row_hi_q;
    filled_d = filled_q;
    char_d   = char_q;
    oor_d    = oor_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (req_i.cmd)
            CMD_CLEAR: begin
              // nothing to do on a zero-sized canvas
              if ((w_eff != '0) && (h_eff != '0)) begin
                col_lo_d = '0;
                row_lo_d = '0;
                col_hi_d = CW'(w_eff - DW'(1));
                row_hi_d = CW'(h_eff - DW'(1));
                col_d    = '0;
                row_d    = '0;
                state_d  = ST_CLEAR;
              end
            end
            CMD_DRAW: begin
              filled_d = req_i.filled;
              char_d   = req_i.paint_char;
              state_d  = ST_BOX0;
            end
            CMD_READ: begin
              oor_d   = !in_range;
              state_d = ST_READ;
            end
            default: ;
          endcase
        end
      end
      ST_BOX0: state_d = ST_BOX1;
      ST_BOX1: begin
        if (box_empty) begin
          state_d = ST_IDLE;
        end else begin
          col_lo_d = box_col_lo;
          col_hi_d = box_col_hi;
          row_lo_d = box_row_lo;
          row_hi_d = box_row_hi;
          col_d    = box_col_lo;
          row_d    = box_row_lo;
          state_d  = ST_DRAW;
        end
      end
      ST_CLEAR, ST_DRAW: begin
        // raster walk, row by row
        if (last_col && last_row) begin
          col_d   = '0;
          row_d   = '0;
          state_d = ST_IDLE;
        end else if (last_col) begin
          col_d = col_lo_q;
          row_d = row_q + CW'(1);
        end else begin
          col_d = col_q + CW'(1);
        end
      end
      ST_READ: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      col_q   <= '0;
      row_q   <= '0;
    end else begin
      state_q <= state_d;
      col_q   <= col_d;
      row_q   <= row_d;
    end
  end

  always_ff @(posedge clk_i) begin
    col_lo_q <= col_lo_d;
    col_hi_q <= col_hi_d;
    row_lo_q <= row_lo_d;
    row_hi_q <= row_hi_d;
    filled_q <= filled_d;
    char_q   <= char_d;
    oor_q    <= oor_d;
  end

  // canvas addressing, cell (col,row) at row*MAX_DIM+col
  assign walk_addr = AW'(row_q) * AW'(MAX_DIM) + AW'(col_q);
  assign read_addr = AW'(req_i.cell_row) * AW'(MAX_DIM) + AW'(req_i.cell_col);

  assign mem_we    = (state_q == ST_CLEAR) || ((state_q == ST_DRAW) && (filled_q || on_edge));
  assign mem_re    = accept && (req_i.cmd == CMD_READ) && in_range;
  assign mem_addr  = (state_q == ST_IDLE) ? read_addr : walk_addr;
  assign mem_wdata = (state_q == ST_CLEAR) ? bg_q : char_q;

  rorf_mem #(
    .DEPTH  (DEPTH),
    .AW     (AW),
    .DATA_W (CHAR_W)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .re_i    (mem_re),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  // read result, in the cycle after the request
  assign rsp_valid_o        = (state_q == ST_READ);
  assign rsp_o.cell_char    = oor_q ? '0 : mem_rdata;
  assign rsp_o.out_of_range = oor_q;

  // a result only comes in the cycle after an accepted request
  a_rsp_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> $past(accept))
    else $error("result without a read request");

  // canvas writes only during a walk
  a_write_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> ((state_q == ST_CLEAR) || (state_q == ST_DRAW)))
    else $error("canvas write outside a walk");

  // walk counters stay inside the box
  a_walk_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_CLEAR) || (state_q == ST_DRAW)) |->
      ((col_q >= col_lo_q) && (col_q <= col_hi_q) &&
       (row_q >= row_lo_q) && (row_q <= row_hi_q)))
    else $error("walk counter outside bounds");

  // counters are back at zero once a walk ends
  a_walk_rewind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (((state_q == ST_CLEAR) || (state_q == ST_DRAW)) && (state_d == ST_IDLE)) |=>
      ((col_q == '0) && (row_q == '0)))
    else $error("walk counters not rewound");

endmodule

`default_nettype wire

### rtl/rorf_mem.sv
`default_nettype none

module rorf_mem #(
  parameter int unsigned DEPTH  = 65536,
  parameter int unsigned AW     = 16,
  parameter int unsigned DATA_W = 8
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic              re_i,
  input  wire logic [AW-1:0]     addr_i,
  input  wire logic [DATA_W-1:0] wdata_i,
  output logic      [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  // single port, registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### rtl/rorf_bbox.sv
`default_nettype none

module rorf_bbox #(
  parameter int unsigned FRAC_BITS = 8,
  parameter int unsigned CW        = 8,
  parameter int unsigned DW        = 9,
  parameter int unsigned SW        = 27
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  load_i,
  input  wire logic signed [rorf_pkg::COORD_W-1:0]   rect_left_i,
  input  wire logic signed [rorf_pkg::COORD_W-1:0]   rect_top_i,
  input  wire logic signed [rorf_pkg::COORD_W-1:0]   rect_span_x_i,
  input  wire logic signed [rorf_pkg::COORD_W-1:0]   rect_span_y_i,
  input  wire logic        [DW-1:0]                  w_eff_i,
  input  wire logic        [DW-1:0]                  h_eff_i,
  output logic                                       empty_o,
  output logic             [CW-1:0]                  col_lo_o,
  output logic             [CW-1:0]                  col_hi_o,
  output logic             [CW-1:0]                  row_lo_o,
  output logic             [CW-1:0]                  row_hi_o,
  output logic signed      [SW-1:0]                  x_lo_edge_o,
  output logic signed      [SW-1:0]                  x_hi_edge_o,
  output logic signed      [SW-1:0]                  y_lo_edge_o,
  output logic signed      [SW-1:0]                  y_hi_edge_o
);

  localparam logic signed [SW-1:0] One   = SW'(1) << FRAC_BITS;
  localparam logic signed [SW-1:0] OneM1 = One - SW'(1);

  logic signed [SW-1:0] left_x, top_y, right_x, bot_y;

  // stage one: integer bounds and edge thresholds
  logic signed [SW-1:0] ceil_l_q, floor_r_q, ceil_t_q, floor_b_q;
  logic signed [SW-1:0] left_p1_q, right_m1_q, top_p1_q, bot_m1_q;
  logic                 span_bad_q;

  // stage two: bounds clamped to the canvas
  logic                 empty_q;
  logic [CW-1:0]        col_lo_q, col_hi_q, row_lo_q, row_hi_q;

  logic signed [SW-1:0] w_s, h_s;

  always_comb begin
    left_x  = SW'(rect_left_i);
    top_y   = SW'(rect_top_i);
    right_x = left_x + SW'(rect_span_x_i);
    bot_y   = top_y + SW'(rect_span_y_i);
    w_s     = $signed(SW'(w_eff_i));
    h_s     = $signed(SW'(h_eff_i));
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      ceil_l_q   <= (left_x + OneM1) >>> FRAC_BITS;
      ceil_t_q   <= (top_y + OneM1) >>> FRAC_BITS;
      floor_r_q  <= right_x >>> FRAC_BITS;
      floor_b_q  <= bot_y >>> FRAC_BITS;
      left_p1_q  <= left_x + One;
      right_m1_q <= right_x - One;
      top_p1_q   <= top_y + One;
      bot_m1_q   <= bot_y - One;
      span_bad_q <= (rect_span_x_i <= 0) || (rect_span_y_i <= 0);
    end
  end

  // a span lying between two whole units covers no cell at all
  always_ff @(posedge clk_i) begin
    empty_q  <= span_bad_q || (w_eff_i == '0) || (h_eff_i == '0) ||
                (floor_r_q < 0) || (ceil_l_q >= w_s) ||
                (floor_b_q < 0) || (ceil_t_q >= h_s) ||
                (ceil_l_q > floor_r_q) || (ceil_t_q > floor_b_q);
    col_lo_q <= (ceil_l_q < 0) ? '0 : ceil_l_q[CW-1:0];
    row_lo_q <= (ceil_t_q < 0) ? '0 : ceil_t_q[CW-1:0];
    col_hi_q <= (floor_r_q >= w_s) ? CW'(w_eff_i - DW'(1)) : floor_r_q[CW-1:0];
    row_hi_q <= (floor_b_q >= h_s) ? CW'(h_eff_i - DW'(1)) : floor_b_q[CW-1:0];
  end

  assign empty_o     = empty_q;
  assign col_lo_o    = col_lo_q;
  assign col_hi_o    = col_hi_q;
  assign row_lo_o    = row_lo_q;
  assign row_hi_o    = row_hi_q;
  assign x_lo_edge_o = left_p1_q;
  assign x_hi_edge_o = right_m1_q;
  assign y_lo_edge_o = top_p1_q;
  assign y_hi_edge_o = bot_m1_q;

endmodule

`default_nettype wire
